[rtl/core/rtfs_pkg.sv]
// ----------------------------------------------------------------------------
// rtfs_pkg
// Shared types, constants and helpers of the raw track format scanner.
// ----------------------------------------------------------------------------
package rtfs_pkg;

    // default width of byte positions inside the track image
    localparam int POSITION_BITS_DEFAULT = 16;

    // field widths of the channels
    localparam int BYTE_BITS      = 8;
    localparam int OUT_POS_BITS   = 16;
    localparam int SECT_LEN_BITS  = 11;
    localparam int COUNT_BITS     = 8;
    localparam int ID_BITS        = 9;
    localparam int CAP_STEP_BITS  = 3;
    localparam int CFG_INDEX_BITS = 2;

    // sector length is 128 shifted by the low two bits of the size code
    localparam logic [SECT_LEN_BITS-1:0] BASE_SECTOR_LEN = SECT_LEN_BITS'(128);
    localparam logic [BYTE_BITS-1:0]     SIZE_CODE_MASK  = 8'h03;

    // first track/side id before any id field was seen
    localparam logic [ID_BITS-1:0] ID_NONE = 9'h100;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // reset values of the mark codes
    localparam logic [BYTE_BITS-1:0] INDEX_MARK_RESET = 8'd252;
    localparam logic [BYTE_BITS-1:0] ID_MARK_RESET    = 8'd254;
    localparam logic [BYTE_BITS-1:0] DATA_MARK_RESET  = 8'd251;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_INDEX_MARK = 2'd0,
        CFG_ID_MARK    = 2'd1,
        CFG_DATA_MARK  = 2'd2
    } rtfs_cfg_index_t;

    // steps of the id field capture
    typedef enum logic [CAP_STEP_BITS-1:0] {
        CAP_IDLE   = 3'd0,
        CAP_TRACK  = 3'd1,
        CAP_SIDE   = 3'd2,
        CAP_SECTOR = 3'd3,
        CAP_SIZE   = 3'd4
    } rtfs_cap_step_t;

    // current mark codes handed from the register file to the engine
    typedef struct packed {
        logic [BYTE_BITS-1:0] index_mark;
        logic [BYTE_BITS-1:0] id_mark;
        logic [BYTE_BITS-1:0] data_mark;
    } rtfs_marks_t;

    // one layout result
    typedef struct packed {
        logic [OUT_POS_BITS-1:0]  track_length;
        logic [SECT_LEN_BITS-1:0] sector_length;
        logic [COUNT_BITS-1:0]    sector_count;
        logic [OUT_POS_BITS-1:0]  index_gap;
        logic [OUT_POS_BITS-1:0]  data_gap;
        logic                     recognized;
        logic                     track_mismatch;
        logic                     side_mismatch;
        logic                     length_mismatch;
        logic                     gap_mismatch;
        logic                     ended_by_index;
    } rtfs_result_t;

    // mismatch flag bits
    typedef struct packed {
        logic gap;
        logic length;
        logic side;
        logic track;
    } rtfs_flags_t;

    function automatic logic [SECT_LEN_BITS-1:0] sector_bytes(input logic [BYTE_BITS-1:0] code);
        logic [BYTE_BITS-1:0] sel;
        sel = code & SIZE_CODE_MASK;
        return BASE_SECTOR_LEN << sel[1:0];
    endfunction

endpackage

[rtl/core/rtfs_ifs.sv]
// ----------------------------------------------------------------------------
// rtfs channel interfaces
// Valid/ready channels for track bytes, layout results and register writes.
// ----------------------------------------------------------------------------
interface rtfs_byte_if;
    logic                          valid;
    logic                          ready;
    logic [rtfs_pkg::BYTE_BITS-1:0] track_byte;
    logic                          first_byte;
    logic                          last_byte;

    modport source (output valid, output track_byte, output first_byte, output last_byte,
                    input ready);
    modport sink (input valid, input track_byte, input first_byte, input last_byte,
                  output ready);
endinterface

interface rtfs_layout_if;
    logic                               valid;
    logic                               ready;
    logic [rtfs_pkg::OUT_POS_BITS-1:0]  track_length;
    logic [rtfs_pkg::SECT_LEN_BITS-1:0] sector_length;
    logic [rtfs_pkg::COUNT_BITS-1:0]    sector_count;
    logic [rtfs_pkg::OUT_POS_BITS-1:0]  index_gap;
    logic [rtfs_pkg::OUT_POS_BITS-1:0]  data_gap;
    logic                               recognized;
    logic                               track_mismatch;
    logic                               side_mismatch;
    logic                               length_mismatch;
    logic                               gap_mismatch;
    logic                               ended_by_index;

    modport source (output valid, output track_length, output sector_length,
                    output sector_count, output index_gap, output data_gap,
                    output recognized, output track_mismatch, output side_mismatch,
                    output length_mismatch, output gap_mismatch, output ended_by_index,
                    input ready);
    modport sink (input valid, input track_length, input sector_length,
                  input sector_count, input index_gap, input data_gap,
                  input recognized, input track_mismatch, input side_mismatch,
                  input length_mismatch, input gap_mismatch, input ended_by_index,
                  output ready);
endinterface

interface rtfs_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [rtfs_pkg::CFG_INDEX_BITS-1:0] index;
    logic [rtfs_pkg::BYTE_BITS-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/rtfs_cfg_regs.sv]
// ----------------------------------------------------------------------------
// rtfs_cfg_regs
// Mark code registers written through the configuration channel.
// ----------------------------------------------------------------------------
module rtfs_cfg_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    rtfs_cfg_if.sink              cfg,
    output rtfs_pkg::rtfs_marks_t marks
);

    rtfs_pkg::rtfs_marks_t marks_reg;
    rtfs_pkg::rtfs_marks_t marks_next;

    assign cfg.ready = 1'b1;
    assign marks     = marks_reg;

    always_comb
    begin
        marks_next = marks_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                rtfs_pkg::CFG_INDEX_MARK: marks_next.index_mark = cfg.data;
                rtfs_pkg::CFG_ID_MARK:    marks_next.id_mark    = cfg.data;
                rtfs_pkg::CFG_DATA_MARK:  marks_next.data_mark  = cfg.data;
                default:                  marks_next            = marks_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg.index_mark <= rtfs_pkg::INDEX_MARK_RESET;
            marks_reg.id_mark    <= rtfs_pkg::ID_MARK_RESET;
            marks_reg.data_mark  <= rtfs_pkg::DATA_MARK_RESET;
        end
        else
        begin
            marks_reg <= marks_next;
        end
    end

endmodule

[rtl/core/rtfs_scan_engine.sv]
// ----------------------------------------------------------------------------
// rtfs_scan_engine
// Scan state and the per-byte update; flags a layout when the scan ends.
// ----------------------------------------------------------------------------
module rtfs_scan_engine #(
    parameter int POSITION_BITS = rtfs_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step_en,
    input  logic [rtfs_pkg::BYTE_BITS-1:0]  track_byte,
    input  logic                            first_byte,
    input  logic                            last_byte,
    input  rtfs_pkg::rtfs_marks_t           marks,
    output logic                            emit,
    output rtfs_pkg::rtfs_result_t          result
);

    localparam int PB = POSITION_BITS;
    localparam int LB = rtfs_pkg::SECT_LEN_BITS;
    localparam int IB = rtfs_pkg::ID_BITS;
    localparam int CB = rtfs_pkg::COUNT_BITS;

    // state registers
    logic [PB-1:0] position_reg, first_index_pos_reg, index_gap_reg, data_gap_reg;
    logic [PB-1:0] sector_end_reg;
    logic          index_seen_reg, data_seen_reg, done_reg;
    logic [IB-1:0] track_id_reg, side_id_reg;
    logic [LB-1:0] sector_len_reg, skip_reg;
    logic [CB-1:0] sectors_reg;
    rtfs_pkg::rtfs_cap_step_t cap_reg;
    rtfs_pkg::rtfs_flags_t    flags_reg;

    // state as seen by this byte (cleared on first byte)
    logic [PB-1:0] cur_pos, cur_first_pos, cur_index_gap, cur_data_gap, cur_sector_end;
    logic          cur_index_seen, cur_data_seen, cur_done;
    logic [IB-1:0] cur_track, cur_side;
    logic [LB-1:0] cur_len, cur_skip;
    logic [CB-1:0] cur_sectors;
    rtfs_pkg::rtfs_cap_step_t cur_cap;
    rtfs_pkg::rtfs_flags_t    cur_flags;

    // next state
    logic [PB-1:0] position_next, first_index_pos_next, index_gap_next, data_gap_next;
    logic [PB-1:0] sector_end_next;
    logic          index_seen_next, data_seen_next, done_next;
    logic [IB-1:0] track_id_next, side_id_next;
    logic [LB-1:0] sector_len_next, skip_next;
    logic [CB-1:0] sectors_next;
    rtfs_pkg::rtfs_cap_step_t cap_next;
    rtfs_pkg::rtfs_flags_t    flags_next;

    logic [PB:0]   pos_sum, end_sum;
    logic [PB-1:0] pos_inc, end_sat, gap, trk_len;
    logic          is_idx, is_id, is_data, skipping, capture_en, by_index;
    logic [IB-1:0] byte_id;
    logic [LB-1:0] size_len;

    function automatic logic [rtfs_pkg::OUT_POS_BITS-1:0] sat16(input logic [PB-1:0] v);
        logic [PB-1:0] hi;
        hi = v >> rtfs_pkg::OUT_POS_BITS;
        return (hi != '0) ? '1 : rtfs_pkg::OUT_POS_BITS'(v);
    endfunction

    assign cur_pos        = first_byte ? '0 : position_reg;
    assign cur_first_pos  = first_byte ? '0 : first_index_pos_reg;
    assign cur_index_gap  = first_byte ? '0 : index_gap_reg;
    assign cur_data_gap   = first_byte ? '0 : data_gap_reg;
    assign cur_sector_end = first_byte ? '0 : sector_end_reg;
    assign cur_index_seen = first_byte ? 1'b0 : index_seen_reg;
    assign cur_data_seen  = first_byte ? 1'b0 : data_seen_reg;
    assign cur_done       = first_byte ? 1'b0 : done_reg;
    assign cur_track      = first_byte ? rtfs_pkg::ID_NONE : track_id_reg;
    assign cur_side       = first_byte ? rtfs_pkg::ID_NONE : side_id_reg;
    assign cur_len        = first_byte ? '0 : sector_len_reg;
    assign cur_skip       = first_byte ? '0 : skip_reg;
    assign cur_sectors    = first_byte ? '0 : sectors_reg;
    assign cur_cap        = first_byte ? rtfs_pkg::CAP_IDLE : cap_reg;
    assign cur_flags      = first_byte ? '0 : flags_reg;

    // mark decode with index over id over data
    assign is_idx  = (track_byte == marks.index_mark);
    assign is_id   = (track_byte == marks.id_mark) && !is_idx;
    assign is_data = (track_byte == marks.data_mark) && !is_idx && !is_id;

    assign skipping   = (cur_skip != '0);
    assign capture_en = (cur_cap != rtfs_pkg::CAP_IDLE) && (skipping || !is_id);
    assign byte_id    = IB'(track_byte);
    assign size_len   = rtfs_pkg::sector_bytes(track_byte);

    // saturating position increment
    assign pos_sum = {1'b0, cur_pos} + (PB+1)'(1);
    assign pos_inc = pos_sum[PB] ? '1 : pos_sum[PB-1:0];

    // end of the sector that a data mark opens, from the length after capture
    assign end_sum = {1'b0, cur_pos} + (PB+1)'(sector_len_next) + (PB+1)'(1);
    assign end_sat = end_sum[PB] ? '1 : end_sum[PB-1:0];
    assign gap     = (pos_inc >= cur_sector_end) ? (pos_inc - cur_sector_end) : '0;

    always_comb
    begin
        position_next        = cur_pos;
        first_index_pos_next = cur_first_pos;
        index_gap_next       = cur_index_gap;
        data_gap_next        = cur_data_gap;
        sector_end_next      = cur_sector_end;
        index_seen_next      = cur_index_seen;
        data_seen_next       = cur_data_seen;
        done_next            = cur_done;
        track_id_next        = cur_track;
        side_id_next         = cur_side;
        sector_len_next      = cur_len;
        skip_next            = cur_skip;
        sectors_next         = cur_sectors;
        cap_next             = cur_cap;
        flags_next           = cur_flags;
        emit                 = 1'b0;
        by_index             = 1'b0;
        trk_len              = '0;

        if (!cur_done)
        begin
            position_next = pos_inc;

            // pending id field
            if (capture_en)
            begin
                case (cur_cap)
                    rtfs_pkg::CAP_TRACK:
                    begin
                        if (cur_track == rtfs_pkg::ID_NONE)
                            track_id_next = byte_id;
                        else if (cur_track != byte_id)
                            flags_next.track = 1'b1;
                    end
                    rtfs_pkg::CAP_SIDE:
                    begin
                        if (cur_side == rtfs_pkg::ID_NONE)
                            side_id_next = byte_id;
                        else if (cur_side != byte_id)
                            flags_next.side = 1'b1;
                    end
                    rtfs_pkg::CAP_SIZE:
                    begin
                        if (cur_len != '0 && size_len != cur_len)
                            flags_next.length = 1'b1;
                        sector_len_next = size_len;
                    end
                    default:
                    begin
                    end
                endcase
                case (cur_cap)
                    rtfs_pkg::CAP_TRACK:  cap_next = rtfs_pkg::CAP_SIDE;
                    rtfs_pkg::CAP_SIDE:   cap_next = rtfs_pkg::CAP_SECTOR;
                    rtfs_pkg::CAP_SECTOR: cap_next = rtfs_pkg::CAP_SIZE;
                    default:              cap_next = rtfs_pkg::CAP_IDLE;
                endcase
            end

            if (skipping)
            begin
                skip_next = cur_skip - LB'(1);
            end
            else if (is_idx)
            begin
                if (!cur_index_seen)
                begin
                    index_seen_next      = 1'b1;
                    first_index_pos_next = cur_pos;
                end
                else
                begin
                    emit     = 1'b1;
                    by_index = 1'b1;
                    trk_len  = cur_pos - cur_first_pos;
                end
            end
            else if (is_id)
            begin
                cap_next = rtfs_pkg::CAP_TRACK;
            end
            else if (is_data)
            begin
                if (!cur_data_seen)
                begin
                    data_seen_next = 1'b1;
                    index_gap_next = pos_inc;
                end
                else if (cur_data_gap == '0)
                begin
                    data_gap_next = gap;
                end
                else if (cur_data_gap != gap)
                begin
                    flags_next.gap = 1'b1;
                end
                if (cur_sectors != rtfs_pkg::COUNT_MAX)
                    sectors_next = cur_sectors + CB'(1);
                skip_next       = sector_len_next;
                sector_end_next = end_sat;
            end

            if (last_byte)
                emit = 1'b1;
            if (emit)
                done_next = 1'b1;
        end
    end

    always_comb
    begin
        result.track_length    = sat16(trk_len);
        result.sector_length   = sector_len_next;
        result.sector_count    = sectors_next;
        result.index_gap       = sat16(index_gap_next);
        result.data_gap        = sat16(data_gap_next);
        result.recognized      = (trk_len != '0) && (sector_len_next != '0)
                                 && (data_gap_next != '0) && (sectors_next != '0)
                                 && (track_id_next == '0) && (side_id_next == '0);
        result.track_mismatch  = flags_next.track;
        result.side_mismatch   = flags_next.side;
        result.length_mismatch = flags_next.length;
        result.gap_mismatch    = flags_next.gap;
        result.ended_by_index  = by_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg        <= '0;
            first_index_pos_reg <= '0;
            index_gap_reg       <= '0;
            data_gap_reg        <= '0;
            sector_end_reg      <= '0;
            index_seen_reg      <= 1'b0;
            data_seen_reg       <= 1'b0;
            done_reg            <= 1'b0;
            track_id_reg        <= rtfs_pkg::ID_NONE;
            side_id_reg         <= rtfs_pkg::ID_NONE;
            sector_len_reg      <= '0;
            skip_reg            <= '0;
            sectors_reg         <= '0;
            cap_reg             <= rtfs_pkg::CAP_IDLE;
            flags_reg           <= '0;
        end
        else if (step_en)
        begin
            position_reg        <= position_next;
            first_index_pos_reg <= first_index_pos_next;
            index_gap_reg       <= index_gap_next;
            data_gap_reg        <= data_gap_next;
            sector_end_reg      <= sector_end_next;
            index_seen_reg      <= index_seen_next;
            data_seen_reg       <= data_seen_next;
            done_reg            <= done_next;
            track_id_reg        <= track_id_next;
            side_id_reg         <= side_id_next;
            sector_len_reg      <= sector_len_next;
            skip_reg            <= skip_next;
            sectors_reg         <= sectors_next;
            cap_reg             <= cap_next;
            flags_reg           <= flags_next;
        end
    end

endmodule

[rtl/core/raw_track_format_scanner_core.sv]
// ----------------------------------------------------------------------------
// raw_track_format_scanner_core
// Scans raw floppy track bytes and reports the track layout at scan end.
// ----------------------------------------------------------------------------
// path: the closing byte transaction enters the input register, then the
//   scan update loads the result register that drives the layout channel
// throughput: one byte per cycle from the combinational scan update; a layout
//   held by the sink stalls the byte channel until it is taken
// reset: rst_n clears the scan state and loads the default mark codes
//   (index 252, id 254, data 251); no clearing pass is needed
module raw_track_format_scanner_core #(
    parameter int POSITION_BITS = rtfs_pkg::POSITION_BITS_DEFAULT
) (
    input logic           clk,
    input logic           rst_n,
    rtfs_byte_if.sink     track,
    rtfs_layout_if.source layout,
    rtfs_cfg_if.sink      cfg
);

    // input register
    logic                           in_valid_reg;
    logic [rtfs_pkg::BYTE_BITS-1:0] in_byte_reg;
    logic                           in_first_reg;
    logic                           in_last_reg;

    // result register
    logic                   out_valid_reg;
    rtfs_pkg::rtfs_result_t out_result_reg;

    rtfs_pkg::rtfs_marks_t  marks;
    rtfs_pkg::rtfs_result_t result;
    logic                   emit;
    logic                   advance;

    // the held byte moves into the scan state whenever the result slot is
    // free or is being drained in this cycle
    assign advance     = in_valid_reg && (!out_valid_reg || layout.ready);
    assign track.ready = !in_valid_reg || advance;

    // mark code registers
    rtfs_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .marks (marks)
    );

    // scan state and per-byte update
    rtfs_scan_engine #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance),
        .track_byte (in_byte_reg),
        .first_byte (in_first_reg),
        .last_byte  (in_last_reg),
        .marks      (marks),
        .emit       (emit),
        .result     (result)
    );

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (track.ready)
        begin
            in_valid_reg <= track.valid;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (track.valid && track.ready)
        begin
            in_byte_reg  <= track.track_byte;
            in_first_reg <= track.first_byte;
            in_last_reg  <= track.last_byte;
        end
    end

    // result register control: load on a finishing byte, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (layout.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_result_reg <= result;
        end
    end

    // drive the layout channel
    assign layout.valid           = out_valid_reg;
    assign layout.track_length    = out_result_reg.track_length;
    assign layout.sector_length   = out_result_reg.sector_length;
    assign layout.sector_count    = out_result_reg.sector_count;
    assign layout.index_gap       = out_result_reg.index_gap;
    assign layout.data_gap        = out_result_reg.data_gap;
    assign layout.recognized      = out_result_reg.recognized;
    assign layout.track_mismatch  = out_result_reg.track_mismatch;
    assign layout.side_mismatch   = out_result_reg.side_mismatch;
    assign layout.length_mismatch = out_result_reg.length_mismatch;
    assign layout.gap_mismatch    = out_result_reg.gap_mismatch;
    assign layout.ended_by_index  = out_result_reg.ended_by_index;

endmodule

[verif/tb_raw_track_format_scanner_core.sv]
// ----------------------------------------------------------------------------
// tb_raw_track_format_scanner_core
// Self-checking bench for the raw track format scanner. A scan model of its
// own follows every accepted track byte and queues the layout that each scan
// must report. Each layout transaction is compared field by field. Stimulus
// is a directed opening, then per phase one well-formed track followed by
// noise and broken id captures, each phase under its own mark code settings.
// ----------------------------------------------------------------------------
module tb_raw_track_format_scanner_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rtfs_pkg::*;

    // scan positions as the block counts them (default parameter)
    localparam int POS_BITS = POSITION_BITS_DEFAULT;
    localparam int unsigned POS_MAX = (32'd1 << POS_BITS) - 1;
    // idle cycles after the last layout is back, before touching the registers
    localparam int SETTLE_CYCLES = 8;
    // quiet cycles that the watchdog allows before it fails the run
    localparam int QUIET_LIMIT = 2000;
    // bytes per random phase before the phase may close
    localparam int unsigned PHASE_ITEMS = 100;

    // one byte transaction as queued for the driver
    typedef struct packed {
        logic [BYTE_BITS-1:0] value;
        logic                 first;
        logic                 last;
    } raw_byte_t;

    logic clk;
    logic rst_n;

    rtfs_byte_if   trk ();
    rtfs_layout_if lay ();
    rtfs_cfg_if    cfg ();

    raw_track_format_scanner_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .track  (trk),
        .layout (lay),
        .cfg    (cfg)
    );

    // byte transactions waiting for the driver, layouts still owed by the block
    raw_byte_t    byte_q[$];
    rtfs_result_t pending_layouts[$];

    raw_byte_t    next_byte;
    rtfs_result_t want;

    int unsigned items_queued;
    int unsigned items_taken;
    int unsigned fail_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned phase_items;

    // mark codes as currently written
    logic [BYTE_BITS-1:0] mk_index;
    logic [BYTE_BITS-1:0] mk_id;
    logic [BYTE_BITS-1:0] mk_data;

    // scan state of the model
    int unsigned        sc_pos;
    int unsigned        sc_index_pos;
    bit                 sc_index_seen;
    logic [ID_BITS-1:0] sc_track_id;
    logic [ID_BITS-1:0] sc_side_id;
    int unsigned        sc_sect_len;
    int unsigned        sc_sectors;
    bit                 sc_data_seen;
    int unsigned        sc_index_gap;
    int unsigned        sc_data_gap;
    int unsigned        sc_sect_end;
    int unsigned        sc_skip;
    rtfs_cap_step_t     sc_cap;
    rtfs_flags_t        sc_flags;
    bit                 sc_done;

    // ------------------------------------------------------------------------
    // scan model
    // ------------------------------------------------------------------------
    function automatic int unsigned clip_pos(input int unsigned v);
        return (v > POS_MAX) ? POS_MAX : v;
    endfunction

    function automatic logic [OUT_POS_BITS-1:0] clip_out(input int unsigned v);
        return (v > 32'hFFFF) ? 16'hFFFF : v[OUT_POS_BITS-1:0];
    endfunction

    function automatic void restart_scan();
        sc_pos        = 0;
        sc_index_pos  = 0;
        sc_index_seen = 1'b0;
        sc_track_id   = ID_NONE;
        sc_side_id    = ID_NONE;
        sc_sect_len   = 0;
        sc_sectors    = 0;
        sc_data_seen  = 1'b0;
        sc_index_gap  = 0;
        sc_data_gap   = 0;
        sc_sect_end   = 0;
        sc_skip       = 0;
        sc_cap        = CAP_IDLE;
        sc_flags      = '0;
        sc_done       = 1'b0;
    endfunction

    // one id field byte: track, side, sector number (unused), size code
    function automatic void take_id_field(input logic [BYTE_BITS-1:0] b);
        int unsigned len;
        case (sc_cap)
            CAP_TRACK:
            begin
                if (sc_track_id == ID_NONE)
                    sc_track_id = {1'b0, b};
                else if (sc_track_id != {1'b0, b})
                    sc_flags.track = 1'b1;
            end
            CAP_SIDE:
            begin
                if (sc_side_id == ID_NONE)
                    sc_side_id = {1'b0, b};
                else if (sc_side_id != {1'b0, b})
                    sc_flags.side = 1'b1;
            end
            CAP_SIZE:
            begin
                len = int'(BASE_SECTOR_LEN) << (b & SIZE_CODE_MASK);
                if (sc_sect_len != 0 && len != sc_sect_len)
                    sc_flags.length = 1'b1;
                sc_sect_len = len;
            end
            default: ;
        endcase
        sc_cap = (sc_cap == CAP_SIZE) ? CAP_IDLE : rtfs_cap_step_t'(sc_cap + 1);
    endfunction

    // end of scan: queue the layout the block owes
    function automatic void close_scan(input int unsigned span, input bit by_index);
        rtfs_result_t r;
        r.track_length    = clip_out(span);
        r.sector_length   = sc_sect_len[SECT_LEN_BITS-1:0];
        r.sector_count    = sc_sectors[COUNT_BITS-1:0];
        r.index_gap       = clip_out(sc_index_gap);
        r.data_gap        = clip_out(sc_data_gap);
        r.recognized      = span != 0 && sc_sect_len != 0 && sc_data_gap != 0 &&
                            sc_sectors != 0 && sc_track_id == 0 && sc_side_id == 0;
        r.track_mismatch  = sc_flags.track;
        r.side_mismatch   = sc_flags.side;
        r.length_mismatch = sc_flags.length;
        r.gap_mismatch    = sc_flags.gap;
        r.ended_by_index  = by_index;
        pending_layouts.push_back(r);
        sc_done = 1'b1;
    endfunction

    function automatic void advance_scan(input logic [BYTE_BITS-1:0] b,
                                         input bit first, input bit last);
        int unsigned p;
        int unsigned after;
        int unsigned gap;
        bit          is_id;
        if (first)
            restart_scan();
        if (sc_done)
            return;
        p = sc_pos;
        sc_pos = clip_pos(p + 1);
        if (sc_skip != 0)
        begin
            // inside a sector body: no marks, but id fields still land
            sc_skip--;
            if (sc_cap != CAP_IDLE)
                take_id_field(b);
        end
        else
        begin
            // index beats id, id beats data; a repeated id restarts the capture
            is_id = (b == mk_id) && (b != mk_index);
            if (sc_cap != CAP_IDLE && !is_id)
                take_id_field(b);
            if (b == mk_index)
            begin
                if (!sc_index_seen)
                begin
                    sc_index_seen = 1'b1;
                    sc_index_pos  = p;
                end
                else
                begin
                    close_scan(p - sc_index_pos, 1'b1);
                    return;
                end
            end
            else if (b == mk_id)
            begin
                sc_cap = CAP_TRACK;
            end
            else if (b == mk_data)
            begin
                after = clip_pos(p + 1);
                if (!sc_data_seen)
                begin
                    sc_data_seen = 1'b1;
                    sc_index_gap = after;
                end
                else
                begin
                    gap = (after >= sc_sect_end) ? after - sc_sect_end : 0;
                    if (sc_data_gap == 0)
                        sc_data_gap = gap;
                    else if (sc_data_gap != gap)
                        sc_flags.gap = 1'b1;
                end
                if (sc_sectors < COUNT_MAX)
                    sc_sectors++;
                sc_skip     = sc_sect_len;
                sc_sect_end = clip_pos(p + sc_sect_len + 1);
            end
        end
        if (last)
            close_scan(0, 1'b0);
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void push_byte(input logic [BYTE_BITS-1:0] v,
                                      input bit first = 1'b0, input bit last = 1'b0);
        raw_byte_t item;
        item.value = v;
        item.first = first;
        item.last  = last;
        byte_q.push_back(item);
        items_queued++;
        phase_items++;
    endfunction

    // any byte that is none of the current marks
    function automatic logic [BYTE_BITS-1:0] plain_byte();
        logic [BYTE_BITS-1:0] v;
        v = 8'($urandom);
        while (v == mk_index || v == mk_id || v == mk_data)
            v = 8'($urandom);
        return v;
    endfunction

    function automatic logic [BYTE_BITS-1:0] any_mark();
        case ($urandom_range(2))
            0:       return mk_index;
            1:       return mk_id;
            default: return mk_data;
        endcase
    endfunction

    // gap, index, then sectors of id + fields + data mark + body; the last
    // sector is mostly cut short by the last byte, else the track closes
    function automatic void build_track();
        int unsigned          n_sec;
        int unsigned          gap_lead;
        int unsigned          gap_data;
        int unsigned          code;
        int unsigned          s;
        bit                   steady;
        bit                   cut;
        logic [BYTE_BITS-1:0] trk_no;
        logic [BYTE_BITS-1:0] side_no;
        n_sec    = ($urandom_range(3) == 0) ? 2 : 1;
        cut      = ($urandom_range(3) != 0);
        steady   = $urandom_range(1);
        gap_lead = $urandom_range(4);
        gap_data = $urandom_range(4);
        trk_no   = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00;
        side_no  = ($urandom_range(3) == 0) ? 8'($urandom_range(1)) : 8'h00;
        push_byte(plain_byte(), 1'b1);
        repeat ($urandom_range(3)) push_byte(plain_byte());
        push_byte(mk_index);
        for (s = 0; s < n_sec; s++)
        begin
            repeat (steady ? gap_lead : $urandom_range(4)) push_byte(plain_byte());
            push_byte(mk_id);
            push_byte(($urandom_range(7) == 0) ? 8'($urandom) : trk_no);
            push_byte(($urandom_range(7) == 0) ? 8'($urandom) : side_no);
            push_byte(($urandom_range(15) == 0) ? 8'($urandom) : plain_byte());
            // a cut sector may carry any size, full ones are mostly short
            if (cut && s == n_sec - 1)
                code = $urandom_range(3);
            else
                code = ($urandom_range(7) == 0) ? 1 : 0;
            push_byte({6'($urandom), 2'(code)});
            repeat (steady ? gap_data : $urandom_range(4)) push_byte(plain_byte());
            push_byte(mk_data);
            if (cut && s == n_sec - 1)
            begin
                // last byte lands inside the sector body
                repeat ($urandom_range(12)) push_byte(8'($urandom));
                push_byte(8'($urandom), 1'b0, 1'b1);
                return;
            end
            repeat (128 << code) push_byte(8'($urandom));
        end
        repeat ($urandom_range(3)) push_byte(plain_byte());
        if ($urandom_range(2) != 0)
        begin
            push_byte(mk_index, 1'b0, $urandom_range(1));
            // trailing bytes after the end are dropped by the block
            repeat ($urandom_range(2)) push_byte(8'($urandom), 1'b0, $urandom_range(1));
        end
        else
        begin
            push_byte(plain_byte(), 1'b0, 1'b1);
        end
    endfunction

    // short scan of marks and random bytes
    function automatic void noise_scan();
        int unsigned len;
        int unsigned i;
        len = $urandom_range(1, 16);
        for (i = 0; i < len; i++)
            push_byte($urandom_range(1) ? any_mark() : 8'($urandom),
                      (i == 0) && ($urandom_range(7) != 0),
                      (i == len - 1) || ($urandom_range(15) == 0));
    endfunction

    // id mark repeated inside its own capture, then cut off inside the sector
    function automatic void broken_capture();
        int unsigned code;
        push_byte(plain_byte(), 1'b1);
        push_byte(mk_index);
        push_byte(mk_id);
        repeat ($urandom_range(3)) push_byte(plain_byte());
        push_byte(mk_id);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(plain_byte());
        code = $urandom_range(3);
        push_byte({6'($urandom), 2'(code)});
        push_byte(mk_data);
        repeat ($urandom_range(12)) push_byte(8'($urandom));
        push_byte(8'($urandom), 1'b0, 1'b1);
    endfunction

    // ------------------------------------------------------------------------
    // checking helpers
    // ------------------------------------------------------------------------
    task automatic note_failure(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] exp_val);
        if (got !== exp_val)
            note_failure($sformatf("layout %s is %0h, model says %0h", name, got, exp_val));
    endtask

    // ------------------------------------------------------------------------
    // register writes and phase boundaries
    // ------------------------------------------------------------------------
    task automatic write_mark(input rtfs_cfg_index_t reg_sel, input logic [BYTE_BITS-1:0] code);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= reg_sel;
        cfg.data  <= code;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        // write transaction taken at this edge
        cfg.valid <= 1'b0;
        case (reg_sel)
            CFG_INDEX_MARK: mk_index = code;
            CFG_ID_MARK:    mk_id    = code;
            default:        mk_data  = code;
        endcase
    endtask

    // sender holds off until every byte is taken and every layout is back
    task automatic settle();
        while (items_taken != items_queued)
            @(posedge clk);
        while (pending_layouts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // byte driver: feeds track transactions, runs the model on acceptance
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            trk.valid <= 1'b0;
        end
        else
        begin
            if (trk.valid && trk.ready)
            begin
                advance_scan(trk.track_byte, trk.first_byte, trk.last_byte);
                items_taken++;
            end
            // load a new byte when the bus is free or just taken
            if (!trk.valid || trk.ready)
            begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_byte = byte_q.pop_front();
                    trk.valid      <= 1'b1;
                    trk.track_byte <= next_byte.value;
                    trk.first_byte <= next_byte.first;
                    trk.last_byte  <= next_byte.last;
                end
                else
                begin
                    trk.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // layout monitor: random backpressure, compare against oldest layout owed
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            lay.ready <= 1'b0;
        end
        else
        begin
            if (lay.valid && lay.ready)
            begin
                if (pending_layouts.size() == 0)
                begin
                    note_failure("layout transaction with no scan end behind it");
                end
                else
                begin
                    want = pending_layouts.pop_front();
                    compare_field("track_length", lay.track_length, want.track_length);
                    compare_field("sector_length", 16'(lay.sector_length),
                                  16'(want.sector_length));
                    compare_field("sector_count", 16'(lay.sector_count),
                                  16'(want.sector_count));
                    compare_field("index_gap", lay.index_gap, want.index_gap);
                    compare_field("data_gap", lay.data_gap, want.data_gap);
                    compare_field("recognized", 16'(lay.recognized),
                                  16'(want.recognized));
                    compare_field("track_mismatch", 16'(lay.track_mismatch),
                                  16'(want.track_mismatch));
                    compare_field("side_mismatch", 16'(lay.side_mismatch),
                                  16'(want.side_mismatch));
                    compare_field("length_mismatch", 16'(lay.length_mismatch),
                                  16'(want.length_mismatch));
                    compare_field("gap_mismatch", 16'(lay.gap_mismatch),
                                  16'(want.gap_mismatch));
                    compare_field("ended_by_index", 16'(lay.ended_by_index),
                                  16'(want.ended_by_index));
                end
            end
            lay.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles with no transaction on any channel
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (trk.valid && trk.ready) || (lay.valid && lay.ready) ||
                (cfg.valid && cfg.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("ERROR @%0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned ph;
        int unsigned pick;

        // every input known from time zero
        trk.valid      = 1'b0;
        trk.track_byte = '0;
        trk.first_byte = 1'b0;
        trk.last_byte  = 1'b0;
        lay.ready      = 1'b0;
        cfg.valid      = 1'b0;
        cfg.index      = CFG_INDEX_MARK;
        cfg.data       = '0;

        items_queued  = 0;
        items_taken   = 0;
        fail_count    = 0;
        phase_items   = 0;
        send_idle_pct = 22;
        recv_idle_pct = 52;
        mk_index      = INDEX_MARK_RESET;
        mk_id         = ID_MARK_RESET;
        mk_data       = DATA_MARK_RESET;
        restart_scan();

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed opening with the reset mark codes
        // id restarted inside its capture, then a size field that is also
        // the second index mark
        push_byte(INDEX_MARK_RESET, 1'b1);
        push_byte(ID_MARK_RESET);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(ID_MARK_RESET);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h01);
        push_byte(INDEX_MARK_RESET);
        // one byte that both opens and closes a scan, and is a data mark
        push_byte(DATA_MARK_RESET, 1'b1, 1'b1);
        // top-value fields, a size field that doubles as a data mark opening
        // the longest sector, then the last byte ends the scan mid-sector
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF);
        push_byte(ID_MARK_RESET);
        push_byte(8'hFF);
        push_byte(8'h01);
        push_byte(8'h80);
        push_byte(DATA_MARK_RESET);
        push_byte(INDEX_MARK_RESET, 1'b0, 1'b1);
        // dropped after the scan end
        push_byte(8'h12);
        push_byte(INDEX_MARK_RESET, 1'b0, 1'b1);
        // short recognized layout: data marks with no sector body yet, then
        // an id with track and side 0, closed by the second index mark
        push_byte(8'h4E, 1'b1);
        push_byte(INDEX_MARK_RESET);
        push_byte(DATA_MARK_RESET);
        push_byte(8'h4E);
        push_byte(DATA_MARK_RESET);
        push_byte(ID_MARK_RESET);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h01);
        push_byte(8'h02);
        push_byte(8'h4E);
        push_byte(INDEX_MARK_RESET);
        settle();

        // random phases, each under its own mark codes
        for (ph = 0; ph < 8; ph++)
        begin
            if (ph == 3)
            begin
                send_idle_pct = 52;
                recv_idle_pct = 22;
            end
            else if (ph == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                1:
                begin
                    // extremes
                    write_mark(CFG_INDEX_MARK, 8'h00);
                    write_mark(CFG_ID_MARK, 8'hFF);
                    write_mark(CFG_DATA_MARK, 8'h80);
                end
                2:
                begin
                    write_mark(CFG_INDEX_MARK, 8'hFF);
                    write_mark(CFG_ID_MARK, 8'h00);
                    write_mark(CFG_DATA_MARK, 8'h01);
                end
                3:
                begin
                    // index and id share a code
                    write_mark(CFG_INDEX_MARK, 8'h77);
                    write_mark(CFG_ID_MARK, 8'h77);
                    write_mark(CFG_DATA_MARK, 8'h33);
                end
                4:
                begin
                    // id and data share a code
                    write_mark(CFG_INDEX_MARK, 8'h10);
                    write_mark(CFG_ID_MARK, 8'h20);
                    write_mark(CFG_DATA_MARK, 8'h20);
                end
                5:
                begin
                    write_mark(CFG_INDEX_MARK, 8'h99);
                    write_mark(CFG_ID_MARK, 8'h44);
                    write_mark(CFG_DATA_MARK, 8'h99);
                end
                6:
                begin
                    // all three alike
                    write_mark(CFG_INDEX_MARK, 8'hC3);
                    write_mark(CFG_ID_MARK, 8'hC3);
                    write_mark(CFG_DATA_MARK, 8'hC3);
                end
                7:
                begin
                    write_mark(CFG_INDEX_MARK, INDEX_MARK_RESET);
                    write_mark(CFG_ID_MARK, ID_MARK_RESET);
                    write_mark(CFG_DATA_MARK, DATA_MARK_RESET);
                end
                default: ;
            endcase
            phase_items = 0;
            build_track();
            while (phase_items < PHASE_ITEMS)
            begin
                pick = $urandom_range(3);
                if (pick == 0)
                    broken_capture();
                else
                    noise_scan();
            end
            settle();
        end

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
